>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

  // permutation size and stream index width
  localparam int PermEntries = 256;
  localparam int ByteW       = 8;
  localparam int KeyLenW     = 9;

  // reset value of the key length register
  localparam logic [KeyLenW-1:0] KeyLenReset = 9'd16;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_D_RD_I,
    OP_D_RD_J,
    OP_D_WR_I,
    OP_D_WR_J,
    OP_K_RD_N,
    OP_K_RD_J,
    OP_K_WR_N,
    OP_K_WR_J
  } op_e;

  // controller to datapath
  typedef struct packed {
    op_e  op;
    logic ks_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_trigger;
    logic n_last;
  } stat_t;

endpackage

>>> hw/rtl/rc4_ctrl.sv
module rc4_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rc4_pkg::stat_t stat_i,
  output rc4_pkg::cmd_t  cmd_o
);
  import rc4_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D2   = 4'd1;
  localparam logic [3:0] S_D3   = 4'd2;
  localparam logic [3:0] S_D4   = 4'd3;
  localparam logic [3:0] S_K1   = 4'd4;
  localparam logic [3:0] S_K2   = 4'd5;
  localparam logic [3:0] S_K3   = 4'd6;
  localparam logic [3:0] S_K4   = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_acc;

  // output slot can take a new item this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // sequencing of data items and key schedule steps
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op       = OP_NONE;
    cmd_o.ks_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i) begin
            cmd_o.op = OP_D_RD_I;
            state_d  = S_D2;
          end else begin
            cmd_o.op = OP_KEY_WR;
            if (stat_i.key_trigger) begin
              cmd_o.ks_start = 1'b1;
              state_d        = S_K1;
            end
          end
        end
      end
      S_D2: begin
        cmd_o.op = OP_D_RD_J;
        state_d  = S_D3;
      end
      S_D3: begin
        cmd_o.op = OP_D_WR_I;
        state_d  = S_D4;
      end
      S_D4: begin
        if (out_free) begin
          cmd_o.op    = OP_D_WR_J;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_K1: begin
        cmd_o.op = OP_K_RD_N;
        state_d  = S_K2;
      end
      S_K2: begin
        cmd_o.op = OP_K_RD_J;
        state_d  = S_K3;
      end
      S_K3: begin
        cmd_o.op = OP_K_WR_N;
        state_d  = S_K4;
      end
      S_K4: begin
        cmd_o.op = OP_K_WR_J;
        state_d  = stat_i.n_last ? S_IDLE : S_K1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // a finished data item with a free slot always shows a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D4 && out_free) |=> out_valid_q)
    else $error("result not presented after final data step");

  // a stalled receiver keeps the last data step waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D4 && !out_free) |=> (state_q == S_D4))
    else $error("data step left while output slot full");

  // last schedule step returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K4 && stat_i.n_last) |=> (state_q == S_IDLE))
    else $error("key schedule did not finish after last step");

  // schedule starts only from an accepted key item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ks_start |-> (in_acc && !kind_i))
    else $error("key schedule started without a key item");
`endif

endmodule

>>> hw/rtl/rc4_dp.sv
module rc4_dp #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::KeyLenW-1:0]   cfg_wdata_i,
  input  logic [7:0]                    key_index_i,
  input  logic [7:0]                    value_i,
  input  logic                          end_of_message_i,
  input  rc4_pkg::cmd_t                 cmd_i,
  output rc4_pkg::stat_t                stat_o,
  output logic [7:0]                    out_byte_o
);
  import rc4_pkg::*;

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(MAX_KEY_BYTES);

  // permutation memory with per-entry valid bits (invalid reads as its index)
  logic [ByteW-1:0]       pmem [PermEntries];
  logic [PermEntries-1:0] pvalid_q;
  logic [ByteW-1:0]       prdata_q, praddr_q;
  logic                   prvalid_q;
  logic [ByteW-1:0]       prd;

  // key store
  logic [ByteW-1:0] kmem [MAX_KEY_BYTES];
  logic [ByteW-1:0] krd_q;

  logic [KeyLenW-1:0] key_length_q;
  logic [KeyLenW-1:0] eff_len, len_m1;
  logic               key_ok;

  logic [ByteW-1:0] si_q, sj_q, n_q, j_q, i_q, sa_q, sb_q, t_q, val_q;
  logic [ByteW-1:0] out_byte_q;
  logic             eom_q;
  logic [KW-1:0]    kp_q;
  logic             kp_last;

  logic             p_re, p_we, k_re, k_we;
  logic [ByteW-1:0] p_raddr, p_waddr, p_wdata;
  logic [ByteW-1:0] ks_byte;

  assign prd = prvalid_q ? prdata_q : praddr_q;

  // effective key length, clamped to 1..MAX_KEY_BYTES
  always_comb begin
    if (key_length_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_length_q > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = key_length_q;
    end
  end

  assign len_m1  = eff_len - KeyLenW'(1);
  assign key_ok  = ({1'b0, key_index_i} < MaxLen);
  assign kp_last = (kp_q == len_m1[KW-1:0]);

  assign stat_o.key_trigger = key_ok && ({1'b0, key_index_i} == len_m1);
  assign stat_o.n_last      = (n_q == ByteW'(PermEntries - 1));

  // keystream byte after the swap, bypassing the swapped entries
  always_comb begin
    if (t_q == i_q) begin
      ks_byte = sb_q;
    end else if (t_q == j_q) begin
      ks_byte = sa_q;
    end else begin
      ks_byte = prd;
    end
  end

  // memory addressing per operation
  always_comb begin
    p_re    = 1'b0;
    p_we    = 1'b0;
    k_re    = 1'b0;
    k_we    = 1'b0;
    p_raddr = '0;
    p_waddr = '0;
    p_wdata = '0;
    case (cmd_i.op)
      OP_KEY_WR: begin
        k_we = key_ok;
      end
      OP_D_RD_I: begin
        p_re    = 1'b1;
        p_raddr = ByteW'(si_q + 8'd1);
      end
      OP_D_RD_J: begin
        p_re    = 1'b1;
        p_raddr = ByteW'(sj_q + prd);
      end
      OP_D_WR_I: begin
        p_re    = 1'b1;
        p_raddr = ByteW'(sa_q + prd);
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = prd;
      end
      OP_D_WR_J: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = sa_q;
      end
      OP_K_RD_N: begin
        p_re    = 1'b1;
        p_raddr = n_q;
        k_re    = 1'b1;
      end
      OP_K_RD_J: begin
        p_re    = 1'b1;
        p_raddr = ByteW'(j_q + prd + krd_q);
      end
      OP_K_WR_N: begin
        p_we    = 1'b1;
        p_waddr = n_q;
        p_wdata = prd;
      end
      OP_K_WR_J: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = sa_q;
      end
      default: begin
        p_re = 1'b0;
      end
    endcase
  end

  // permutation storage and registered read
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      prdata_q  <= pmem[p_raddr];
      prvalid_q <= pvalid_q[p_raddr];
      praddr_q  <= p_raddr;
    end
  end

  // valid bits, cleared at reset and at schedule start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0;
    end else if (cmd_i.ks_start) begin
      pvalid_q <= '0;
    end else if (p_we) begin
      pvalid_q[p_waddr] <= 1'b1;
    end
  end

  // key store and registered read
  always_ff @(posedge clk_i) begin
    if (k_we) begin
      kmem[key_index_i[KW-1:0]] <= value_i;
    end
    if (k_re) begin
      krd_q <= kmem[kp_q];
    end
  end

  // config register, stream indices and schedule counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KeyLenReset;
      si_q         <= '0;
      sj_q         <= '0;
      n_q          <= '0;
      kp_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_KEY_WR: begin
          if (cmd_i.ks_start) begin
            n_q  <= '0;
            kp_q <= '0;
          end
        end
        OP_D_WR_J: begin
          si_q <= eom_q ? '0 : i_q;
          sj_q <= eom_q ? '0 : j_q;
        end
        OP_K_WR_J: begin
          n_q  <= ByteW'(n_q + 8'd1);
          kp_q <= kp_last ? '0 : KW'(kp_q + 1'b1);
          if (stat_o.n_last) begin
            si_q <= '0;
            sj_q <= '0;
          end
        end
        default: begin
          n_q <= n_q;
        end
      endcase
    end
  end

  // working registers of the swap steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_start) begin
      j_q <= '0;
    end
    case (cmd_i.op)
      OP_D_RD_I: begin
        i_q   <= ByteW'(si_q + 8'd1);
        val_q <= value_i;
        eom_q <= end_of_message_i;
      end
      OP_D_RD_J: begin
        sa_q <= prd;
        j_q  <= p_raddr;
      end
      OP_D_WR_I: begin
        sb_q <= prd;
        t_q  <= p_raddr;
      end
      OP_D_WR_J: begin
        out_byte_q <= val_q ^ ks_byte;
      end
      OP_K_RD_J: begin
        sa_q <= prd;
        j_q  <= p_raddr;
      end
      default: begin
        sa_q <= sa_q;
      end
    endcase
  end

  assign out_byte_o = out_byte_q;

endmodule

>>> hw/rtl/rc4_stream_cipher_unit.sv
// RC4 cipher engine
//
// Input channel (valid/ready) carries one item per handshake: kind_i = 0 writes
// value_i into the key store at key_index_i; writing the index key_length-1
// starts the key schedule. kind_i = 1 ciphers value_i; end_of_message_i on a
// data item clears the stream indices after that byte, keeping the permutation.
// Output channel (valid/ready) carries out_byte_o, one item per data item.
// Key length is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the engine is idle, which the block itself does not enforce.
// A data item runs the steps read S[i], read S[j], write S[i] with read S[t],
// write S[j] before the next accept, and its result is registered in the last
// step. A key item needs no further steps; the last key byte adds a schedule
// of 256 steps (read S[n], read S[j], write S[n], write S[j]) during which no
// item is accepted.
// Reset returns the permutation to the identity at once through per-entry
// valid bits, clears the stream indices and sets key length to 16.
// A stalled receiver holds the result; key items are still taken, and the next
// data item is taken and then waits in its last step until the output is free.
module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] key_index_i,
  input  logic [7:0] value_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);
  import rc4_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // memories and swap datapath
  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .key_index_i      (key_index_i),
    .value_i          (value_i),
    .end_of_message_i (end_of_message_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_byte_o       (out_byte_o)
  );

endmodule
